FILE: rtl/ugsc_pkg.sv
// ----------------------------------------------------------------------------
// ugsc_pkg: shared types and constants of the UDP game signature classifier
// Holds the payload types of both channels, the signature words and the
// codes of the rule that matched.
// ----------------------------------------------------------------------------
package ugsc_pkg;

  typedef logic [7:0]  byte_t;
  typedef logic [1:0]  rule_t;
  typedef logic [15:0] pos_t;
  typedef logic [16:0] len_t;

  // Signature words, all big-endian on the wire.
  localparam logic [31:0] MAGIC_LOGIN = 32'h000b_0000;
  localparam logic [15:0] LOGIN_TYPE  = 16'h0008;
  localparam logic [15:0] MAGIC_SYNC  = 16'h001c;
  localparam logic [31:0] SYNC_WORD_A = 32'h0000_0500;
  localparam logic [31:0] SYNC_WORD_B = 32'h0001_0000;
  localparam logic [15:0] MAGIC_NET   = 16'h0018;
  localparam logic [31:0] NET_WORD_B  = 32'h0000_0001;

  // Codes of the rule that matched.
  localparam rule_t RULE_NONE  = 2'd0;
  localparam rule_t RULE_LOGIN = 2'd1;
  localparam rule_t RULE_SYNC  = 2'd2;
  localparam rule_t RULE_NET   = 2'd3;

  // Number of header bytes kept per packet.
  localparam int HDR_BYTES = 16;

endpackage

FILE: rtl/ugsc_if.sv
// ----------------------------------------------------------------------------
// ugsc_if: valid/ready channels of the UDP game signature classifier
// One interface for the payload byte stream and one for the verdicts.
// ----------------------------------------------------------------------------
interface ugsc_in_if;
  logic            valid;
  logic            ready;
  ugsc_pkg::byte_t payload_byte;
  logic            last_byte;

  modport source (output valid, output payload_byte, output last_byte, input ready);
  modport sink   (input valid, input payload_byte, input last_byte, output ready);
endinterface

interface ugsc_out_if;
  logic            valid;
  logic            ready;
  logic            verdict;
  ugsc_pkg::rule_t matched_rule;

  modport source (output valid, output verdict, output matched_rule, input ready);
  modport sink   (input valid, input verdict, input matched_rule, output ready);
endinterface

FILE: rtl/udp_game_signature_classifier.sv
// ----------------------------------------------------------------------------
// udp_game_signature_classifier: per-packet signature check on UDP payloads
// Counts payload bytes, captures the fields the signature rules need and
// gives one verdict item at the end of every packet.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Per item                          Items
//   in_ch    sink       payload_byte, last_byte           one per payload byte
//   out_ch   source     verdict, matched_rule             one per packet
//
// Every accepted byte updates the capture registers in the cycle it is taken,
// so the block takes one byte per clock cycle. The final byte of a packet
// also loads a pending slot with the packet length; as the slot moves on,
// the rule checks run on the capture registers and the verdict lands in the
// output register. The pending slot holds while the output register is
// stalled, and new bytes are then held off so the captures stay intact.
// Reset (rst_n low, synchronous) clears the byte counter, the overflow flag
// and all valid flags; the captured header bytes need no reset.

module udp_game_signature_classifier (
  input  logic            clk,
  input  logic            rst_n,
  ugsc_in_if.sink         in_ch,
  ugsc_out_if.source      out_ch
);

  // Capture state of the packet in flight.
  ugsc_pkg::pos_t  byte_pos_r, byte_pos_nxt;
  logic            too_long_r, too_long_nxt;
  ugsc_pkg::byte_t hdr_r [ugsc_pkg::HDR_BYTES];
  logic [31:0]     far_word_r;
  ugsc_pkg::len_t  far_off_r;
  logic [15:0]     tail_r;

  // Pending classification and output register.
  logic            pend_r;
  ugsc_pkg::len_t  pend_len_r;
  logic            pend_excl_r;
  logic            out_valid_r;
  logic            out_verdict_r;
  ugsc_pkg::rule_t out_rule_r;

  logic            advance;
  logic            accept;
  logic            is_hdr;
  logic            at_pos15;
  ugsc_pkg::len_t  far_off_new;
  ugsc_pkg::len_t  far_off_eff;
  logic [17:0]     far_off_end;
  logic            far_hit;
  ugsc_pkg::rule_t rule_nxt;

  // The pending slot moves on whenever the output register is free or drains.
  assign advance      = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = !pend_r || advance;
  assign accept       = in_ch.valid && in_ch.ready;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.verdict      = out_verdict_r;
  assign out_ch.matched_rule = out_rule_r;

  // Far word offset is set at offset 15 from the value in bytes 14..15, and
  // the compare at that very byte already sees the new offset.
  assign is_hdr      = (byte_pos_r < 16'(ugsc_pkg::HDR_BYTES));
  assign at_pos15    = (byte_pos_r == 16'd15);
  assign far_off_new = 17'd16 + {1'b0, hdr_r[14], in_ch.payload_byte};
  assign far_off_eff = at_pos15 ? far_off_new : far_off_r;
  assign far_off_end = {1'b0, far_off_eff} + 18'd3;
  assign far_hit     = ({1'b0, byte_pos_r} >= far_off_eff) &&
                       ({2'b00, byte_pos_r} <= far_off_end);

  // Byte counter and overflow flag. The counter saturates at its top value,
  // which marks the packet as oversized; both return to zero after the end.
  always_comb begin
    byte_pos_nxt = byte_pos_r;
    too_long_nxt = too_long_r;
    if (accept) begin
      if (in_ch.last_byte) begin
        byte_pos_nxt = '0;
        too_long_nxt = 1'b0;
      end else if (byte_pos_r == 16'hffff) begin
        too_long_nxt = 1'b1;
      end else begin
        byte_pos_nxt = byte_pos_r + 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_pos_r <= '0;
      too_long_r <= 1'b0;
      far_off_r  <= '0;
      tail_r     <= '0;
    end else begin
      byte_pos_r <= byte_pos_nxt;
      too_long_r <= too_long_nxt;
      if (accept) begin
        tail_r <= {tail_r[7:0], in_ch.payload_byte};
        if (!too_long_r && at_pos15) begin
          far_off_r <= far_off_new;
        end
      end
    end
  end

  // Captured payload fields; stale values from an earlier packet are never
  // read because every rule only looks at offsets below the packet length.
  always_ff @(posedge clk) begin
    if (accept && !too_long_r) begin
      if (is_hdr) begin
        hdr_r[byte_pos_r[3:0]] <= in_ch.payload_byte;
      end
      if (far_hit) begin
        far_word_r <= {far_word_r[23:0], in_ch.payload_byte};
      end
    end
  end

  // The final byte loads the pending slot. An oversized packet, or one whose
  // counter sits at its top value, is excluded outright.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else if (accept && in_ch.last_byte) begin
      pend_r <= 1'b1;
    end else if (advance) begin
      pend_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_ch.last_byte) begin
      pend_len_r  <= {1'b0, byte_pos_r} + 17'd1;
      pend_excl_r <= too_long_r || (byte_pos_r == 16'hffff);
    end
  end

  // Rule checks on the captured fields.
  function automatic logic [15:0] be16(input ugsc_pkg::byte_t hi, input ugsc_pkg::byte_t lo);
    return {hi, lo};
  endfunction

  always_comb begin
    logic [15:0] dlen;
    logic [17:0] dlen2;
    logic [17:0] far_end;
    logic [17:0] len18;
    logic        tail_zero;
    logic        login_hit;
    logic        sync_hit;
    logic        net_hit;
    logic        done;

    dlen      = be16(hdr_r[4], hdr_r[5]);
    dlen2     = {1'b0, dlen, 1'b0} + 18'd8;
    far_end   = {2'b00, be16(hdr_r[14], hdr_r[15])} + 18'd20;
    len18     = {1'b0, pend_len_r};
    tail_zero = (tail_r == 16'h0000);
    login_hit = ({be16(hdr_r[0], hdr_r[1]), be16(hdr_r[2], hdr_r[3])} ==
                 ugsc_pkg::MAGIC_LOGIN);
    sync_hit  = (pend_len_r == 17'd16) &&
                (be16(hdr_r[0], hdr_r[1]) == ugsc_pkg::MAGIC_SYNC) &&
                (be16(hdr_r[2], hdr_r[3]) != 16'h0000);
    net_hit   = (pend_len_r > 17'd50) &&
                (be16(hdr_r[0], hdr_r[1]) == ugsc_pkg::MAGIC_NET) &&
                (be16(hdr_r[2], hdr_r[3]) != 16'h0000);
    rule_nxt  = ugsc_pkg::RULE_NONE;
    done      = 1'b0;

    if (pend_excl_r || pend_len_r <= 17'd10) begin
      done = 1'b1;
    end

    // Login request: data length must fit the packet exactly.
    if (!done && login_hit) begin
      if (dlen == 16'h0000 || dlen2 != len18) begin
        done = 1'b1;
      end else if (be16(hdr_r[6], hdr_r[7]) == ugsc_pkg::LOGIN_TYPE && tail_zero) begin
        rule_nxt = ugsc_pkg::RULE_LOGIN;
        done     = 1'b1;
      end
    end

    // Sync message: fixed 16-byte layout.
    if (!done && sync_hit) begin
      if (dlen != 16'd4) begin
        done = 1'b1;
      end else if ({be16(hdr_r[6], hdr_r[7]), be16(hdr_r[8], hdr_r[9])} ==
                     ugsc_pkg::SYNC_WORD_A &&
                   {be16(hdr_r[10], hdr_r[11]), be16(hdr_r[12], hdr_r[13])} ==
                     ugsc_pkg::SYNC_WORD_B &&
                   tail_zero) begin
        rule_nxt = ugsc_pkg::RULE_SYNC;
        done     = 1'b1;
      end
    end

    // Net sync: the far word must lie wholly inside the packet.
    if (!done && net_hit) begin
      if (dlen == 16'h0000 || dlen2 > len18) begin
        done = 1'b1;
      end else if (be16(hdr_r[8], hdr_r[9]) == be16(hdr_r[12], hdr_r[13]) &&
                   far_end < len18 &&
                   (far_word_r == ugsc_pkg::SYNC_WORD_B ||
                    far_word_r == ugsc_pkg::NET_WORD_B) &&
                   tail_zero) begin
        rule_nxt = ugsc_pkg::RULE_NET;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= pend_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && pend_r) begin
      out_verdict_r <= (rule_nxt != ugsc_pkg::RULE_NONE);
      out_rule_r    <= rule_nxt;
    end
  end

endmodule
